@@ sv/tapm_pkg.sv @@
// Package: shared constants, command type and back-end state type for the tabu arc memory.
package tapm_pkg;

    localparam int VERT_W     = 4;
    localparam int ROW_W      = 2 * VERT_W;
    localparam int ROWS       = 1 << ROW_W;
    localparam int POS_W      = 5;
    localparam int PATH_BITS  = 1 << POS_W;
    localparam int SLOT_CAP   = PATH_BITS - 1;
    localparam int SLOT_W     = 3;
    localparam int MAX_TENURE = 1 << SLOT_W;
    localparam int TEN_W      = 4;
    localparam int ENT_W      = ROW_W + POS_W;
    localparam int MARC_DEPTH = MAX_TENURE * PATH_BITS;
    localparam int MARC_AW    = SLOT_W + POS_W;

    typedef enum logic [1:0] {
        CMD_FILL,
        CMD_UPDATE,
        CMD_ARC,
        CMD_OVF
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ROW_W-1:0]   row;
        logic [POS_W-1:0]   pos;
        logic               last;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK_RD,
        BK_WALK_ROW,
        BK_WALK_WR,
        BK_ARC_RD,
        BK_ARC_WR
    } t_back_state;

endpackage

@@ sv/tapm_front.sv @@
// Front end: tracks path position and previous vertex, classifies each vertex into a command.
module tapm_front
    import tapm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_func,
    input  logic [VERT_W-1:0] i_vertex,
    input  logic              i_last_vertex,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic              r_in_path, n_in_path;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [VERT_W-1:0] r_prev, n_prev;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        n_in_path  = r_in_path;
        n_pos      = r_pos;
        n_prev     = r_prev;
        o_cmd.row  = {r_prev, i_vertex};
        o_cmd.pos  = r_pos;
        o_cmd.last = i_last_vertex;
        if (!r_in_path) begin
            o_cmd.kind = i_func ? CMD_UPDATE : CMD_FILL;
            o_cmd.pos  = '0;
        end else if (r_pos == POS_W'(SLOT_CAP)) begin
            o_cmd.kind = CMD_OVF;
        end else begin
            o_cmd.kind = CMD_ARC;
        end
        if (o_push) begin
            n_prev    = i_vertex;
            n_in_path = 1'b1;
            if (!r_in_path) begin
                n_pos = '0;
            end else if (r_pos != POS_W'(SLOT_CAP)) begin
                n_pos = r_pos + 1'b1;
            end
            if (i_last_vertex) begin
                n_in_path = 1'b0;
                n_pos     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_path <= 1'b0;
            r_pos     <= '0;
            r_prev    <= '0;
        end else begin
            r_in_path <= n_in_path;
            r_pos     <= n_pos;
            r_prev    <= n_prev;
        end
    end

endmodule

@@ sv/tapm_queue.sv @@
// Two-entry command queue between front and back ends.
module tapm_queue
    import tapm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ sv/tapm_back.sv @@
// Back end: bit store, move lists, ring control and the result register.
module tapm_back
    import tapm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TEN_W-1:0] i_cfg_data,
    input  logic             i_q_valid,
    input  t_cmd             i_q_data,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_arc_valid,
    output logic [POS_W-1:0] o_arc_position,
    output logic             o_was_tabu,
    output logic             o_overflow,
    output logic [POS_W-1:0] o_arcs_recorded,
    output logic             o_path_done
);

    // storage
    logic [SLOT_CAP-1:0] r_tabu  [ROWS];
    logic [ROWS-1:0]     r_rowv;
    logic [ENT_W-1:0]    r_marcs [MARC_DEPTH];
    logic [SLOT_CAP-1:0] r_row_q;
    logic                r_rowv_q;
    logic [ENT_W-1:0]    r_ent_q;

    t_back_state         r_state, n_state;
    t_cmd                r_cmd, n_cmd, c;
    logic [POS_W-1:0]    r_k, n_k;
    logic [POS_W-1:0]    r_cnt [MAX_TENURE];
    logic [POS_W-1:0]    n_cnt [MAX_TENURE];
    logic [SLOT_W-1:0]   r_ring, n_ring;
    logic [TEN_W-1:0]    r_tenure;

    logic                r_o_valid, n_o_valid;
    logic                r_o_arc, n_o_arc;
    logic [POS_W-1:0]    r_o_pos, n_o_pos;
    logic                r_o_was, n_o_was;
    logic                r_o_ovf, n_o_ovf;
    logic [POS_W-1:0]    r_o_rec, n_o_rec;
    logic                r_o_done, n_o_done;

    logic                out_free;
    logic                produce;
    logic                clear_all;
    logic [ROW_W-1:0]    tabu_raddr;
    logic                tabu_we;
    logic [ROW_W-1:0]    tabu_waddr;
    logic [SLOT_CAP-1:0] tabu_wdata;
    logic [SLOT_CAP-1:0] row_bits;
    logic                marcs_we;
    logic [MARC_AW-1:0]  marcs_waddr;
    logic [ENT_W-1:0]    marcs_wdata;
    logic [MARC_AW-1:0]  marcs_raddr;
    logic [TEN_W-1:0]    eff_ten;
    logic [TEN_W-1:0]    ring_nxt;
    logic                was;

    assign out_free    = !r_o_valid || i_ready;
    assign row_bits    = r_rowv_q ? r_row_q : '0;
    assign marcs_raddr = {r_ring, r_k};
    assign tabu_raddr  = (r_state == BK_WALK_ROW) ? r_ent_q[ENT_W-1:POS_W] : r_cmd.row;
    assign c           = (r_state == BK_IDLE) ? i_q_data : r_cmd;
    assign was         = row_bits[r_cmd.pos];

    always_comb begin
        eff_ten = r_tenure;
        if (r_tenure == '0) eff_ten = TEN_W'(1);
        if (r_tenure > TEN_W'(MAX_TENURE)) eff_ten = TEN_W'(MAX_TENURE);
        ring_nxt = {1'b0, r_ring} + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_ring      = r_ring;
        o_pop       = 1'b0;
        produce     = 1'b0;
        clear_all   = 1'b0;
        tabu_we     = 1'b0;
        tabu_waddr  = r_cmd.row;
        tabu_wdata  = row_bits | (SLOT_CAP'(1) << r_cmd.pos);
        marcs_we    = 1'b0;
        marcs_waddr = {r_ring, r_cnt[r_ring]};
        marcs_wdata = {r_cmd.row, r_cmd.pos};
        n_o_was     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_data;
                    n_k   = '0;
                    unique case (i_q_data.kind)
                        CMD_FILL: begin
                            clear_all = 1'b1;
                            for (int s = 0; s < MAX_TENURE; s++) n_cnt[s] = '0;
                            n_ring  = '0;
                            produce = 1'b1;
                        end
                        CMD_UPDATE: begin
                            if (r_cnt[r_ring] == '0) begin
                                produce = 1'b1;
                            end else begin
                                n_state = BK_WALK_RD;
                            end
                        end
                        CMD_ARC: n_state = BK_ARC_RD;
                        CMD_OVF: produce = 1'b1;
                        default: n_state = BK_IDLE;
                    endcase
                end
            end
            BK_WALK_RD:  n_state = BK_WALK_ROW;
            BK_WALK_ROW: n_state = BK_WALK_WR;
            BK_WALK_WR: begin
                tabu_we    = 1'b1;
                tabu_waddr = r_ent_q[ENT_W-1:POS_W];
                tabu_wdata = row_bits & ~(SLOT_CAP'(1) << r_ent_q[POS_W-1:0]);
                n_k        = r_k + 1'b1;
                if (n_k == r_cnt[r_ring]) begin
                    n_cnt[r_ring] = '0;
                    produce       = 1'b1;
                    n_state       = BK_IDLE;
                end else begin
                    n_state = BK_WALK_RD;
                end
            end
            BK_ARC_RD: n_state = BK_ARC_WR;
            BK_ARC_WR: begin
                n_o_was = was;
                if (!was) begin
                    tabu_we = 1'b1;
                    if (r_cnt[r_ring] != POS_W'(SLOT_CAP)) begin
                        marcs_we      = 1'b1;
                        n_cnt[r_ring] = r_cnt[r_ring] + 1'b1;
                    end
                end
                produce = 1'b1;
                n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase

        // result register
        n_o_valid = r_o_valid && !i_ready;
        n_o_arc   = r_o_arc;
        n_o_pos   = r_o_pos;
        n_o_ovf   = r_o_ovf;
        n_o_rec   = r_o_rec;
        n_o_done  = r_o_done;
        if (!produce) n_o_was = r_o_was;
        if (produce) begin
            n_o_valid = 1'b1;
            n_o_arc   = (c.kind == CMD_ARC) || (c.kind == CMD_OVF);
            n_o_pos   = c.pos;
            n_o_ovf   = (c.kind == CMD_OVF);
            n_o_rec   = n_cnt[n_ring];
            n_o_done  = c.last;
            if (c.last) begin
                if (c.kind == CMD_FILL) begin
                    n_ring = (TEN_W'(1) >= eff_ten) ? '0 : SLOT_W'(1);
                end else begin
                    n_ring = (ring_nxt >= eff_ten) ? '0 : ring_nxt[SLOT_W-1:0];
                end
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_row_q  <= r_tabu[tabu_raddr];
        r_rowv_q <= r_rowv[tabu_raddr];
        if (tabu_we) r_tabu[tabu_waddr] <= tabu_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_ent_q <= r_marcs[marcs_raddr];
        if (marcs_we) r_marcs[marcs_waddr] <= marcs_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowv <= '0;
        end else if (clear_all) begin
            r_rowv <= '0;
        end else if (tabu_we) begin
            r_rowv[tabu_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_k       <= '0;
            r_ring    <= '0;
            r_tenure  <= TEN_W'(MAX_TENURE);
            r_o_valid <= 1'b0;
            for (int s = 0; s < MAX_TENURE; s++) r_cnt[s] <= '0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_ring    <= n_ring;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            if (i_cfg_we) r_tenure <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_o_arc  <= n_o_arc;
        r_o_pos  <= n_o_pos;
        r_o_was  <= n_o_was;
        r_o_ovf  <= n_o_ovf;
        r_o_rec  <= n_o_rec;
        r_o_done <= n_o_done;
    end

    assign o_valid         = r_o_valid;
    assign o_arc_valid     = r_o_arc;
    assign o_arc_position  = r_o_pos;
    assign o_was_tabu      = r_o_was;
    assign o_overflow      = r_o_ovf;
    assign o_arcs_recorded = r_o_rec;
    assign o_path_done     = r_o_done;

endmodule

@@ sv/tabu_arc_position_memory.sv @@
// Top level: tabu arc memory with front classifier, command queue and back end.
//
// Use: a path arrives one vertex per input transaction (i_valid/o_ready), with
// i_func sampled on its first vertex (0 fill, 1 update) and i_last_vertex on the
// final one. Each vertex yields one result transaction (o_valid/i_ready).
// i_cfg_we writes the tenure; write it only while the block is idle.
// Timing: the front takes a vertex per cycle while the two-entry queue is not
// full. The back end does one bit-store read-modify-write per arc: pop, then
// ARC_RD, ARC_WR and the result register. A fill start or a dropped (overflow)
// arc is answered from the idle state. An update start walks the oldest slot's
// list, WALK_RD, WALK_ROW, WALK_WR per recorded arc, set by the single-port move
// list read feeding the bit-store read-modify-write; no arc overlaps the next.
// Reset: store rows all read as zero (per-row valid flags), counts, ring index,
// path tracking and tenure (8) restored at once; no clearing pass.
// Stall: the back end starts a command only when the result register is free,
// so a stalled receiver holds the result and the queue fills, then o_ready drops.
module tabu_arc_position_memory
    import tapm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TEN_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [VERT_W-1:0] i_vertex,
    input  logic              i_last_vertex,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_arc_valid,
    output logic [POS_W-1:0]  o_arc_position,
    output logic              o_was_tabu,
    output logic              o_overflow,
    output logic [POS_W-1:0]  o_arcs_recorded,
    output logic              o_path_done
);

    logic push, pop, q_valid, q_full;
    t_cmd f_cmd, q_cmd;

    tapm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_vertex      (i_vertex),
        .i_last_vertex (i_last_vertex),
        .i_q_full      (q_full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_cmd         (f_cmd)
    );

    tapm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_cmd)
    );

    tapm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_data        (q_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_arc_valid     (o_arc_valid),
        .o_arc_position  (o_arc_position),
        .o_was_tabu      (o_was_tabu),
        .o_overflow      (o_overflow),
        .o_arcs_recorded (o_arcs_recorded),
        .o_path_done     (o_path_done)
    );

    // dropped arc reports the saturated position, never tabu
    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            o_arc_valid && o_arc_position == POS_W'(SLOT_CAP) && !o_was_tabu)
        else $error("overflow result malformed");

    // path start carries no arc information
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_arc_valid |->
            !o_was_tabu && !o_overflow && o_arc_position == '0 && o_arcs_recorded == '0)
        else $error("path start result not clean");

    // back end never pops from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

@@ verif/tabu_arc_position_memory_tb.sv @@
// Testbench for the tabu arc position memory: predicted results checked per transaction.
`timescale 1ns / 100ps

module tabu_arc_position_memory_tb;
    import tapm_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [TEN_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_func = 1'b0;
    logic [VERT_W-1:0] i_vertex = '0;
    logic              i_last_vertex = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_arc_valid;
    logic [POS_W-1:0]  o_arc_position;
    logic              o_was_tabu;
    logic              o_overflow;
    logic [POS_W-1:0]  o_arcs_recorded;
    logic              o_path_done;

    tabu_arc_position_memory u_top (.*);

    always #4 i_clk = ~i_clk;

    // Expected result of one vertex transaction
    typedef struct packed {
        logic             arc_valid;
        logic [POS_W-1:0] arc_position;
        logic             was_tabu;
        logic             overflow;
        logic [POS_W-1:0] arcs_recorded;
        logic             path_done;
    } t_arc_result;

    t_arc_result arc_results_due[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    // Mirror of the tabu memory
    logic [PATH_BITS-1:0] mirror_bits [ROWS];
    logic [ENT_W-1:0]     mirror_moves [MAX_TENURE][SLOT_CAP];
    int unsigned          mirror_counts [MAX_TENURE];
    int unsigned          mirror_ring;
    logic [VERT_W-1:0]    mirror_prev;
    int unsigned          mirror_pos;
    bit                   mirror_in_path;
    logic [TEN_W-1:0]     mirror_tenure;

    function automatic void mirror_clear();
        foreach (mirror_bits[r]) mirror_bits[r] = '0;
        foreach (mirror_counts[s]) mirror_counts[s] = 0;
        mirror_ring = 0;
        mirror_prev = '0;
        mirror_pos = 0;
        mirror_in_path = 1'b0;
        mirror_tenure = 4'd8;
    endfunction

    function automatic t_arc_result predict_arc(logic func, logic [VERT_W-1:0] v, logic last);
        t_arc_result res;
        int unsigned ten;
        logic [ROW_W-1:0] row;
        res = '0;
        if (mirror_ring >= MAX_TENURE) mirror_ring = 0;
        if (!mirror_in_path) begin
            if (!func) begin
                foreach (mirror_bits[r]) mirror_bits[r] = '0;
                foreach (mirror_counts[s]) mirror_counts[s] = 0;
                mirror_ring = 0;
            end else begin
                // unmark everything the oldest slot recorded
                for (int k = 0; k < mirror_counts[mirror_ring]; k++) begin
                    row = mirror_moves[mirror_ring][k][ENT_W-1:POS_W];
                    mirror_bits[row][mirror_moves[mirror_ring][k][POS_W-1:0]] = 1'b0;
                end
                mirror_counts[mirror_ring] = 0;
            end
            mirror_in_path = 1'b1;
            mirror_pos = 0;
        end else begin
            res.arc_valid = 1'b1;
            res.arc_position = mirror_pos[POS_W-1:0];
            if (mirror_pos >= SLOT_CAP) begin
                res.overflow = 1'b1;
            end else begin
                row = {mirror_prev, v};
                if (mirror_bits[row][mirror_pos]) begin
                    res.was_tabu = 1'b1;
                end else begin
                    mirror_bits[row][mirror_pos] = 1'b1;
                    if (mirror_counts[mirror_ring] < SLOT_CAP) begin
                        mirror_moves[mirror_ring][mirror_counts[mirror_ring]] =
                            {row, mirror_pos[POS_W-1:0]};
                        mirror_counts[mirror_ring]++;
                    end
                end
                mirror_pos++;
            end
        end
        mirror_prev = v;
        res.arcs_recorded = mirror_counts[mirror_ring][POS_W-1:0];
        res.path_done = last;
        if (last) begin
            ten = (mirror_tenure == 0) ? 1 : (mirror_tenure > MAX_TENURE) ? MAX_TENURE
                                                                          : mirror_tenure;
            mirror_ring = (mirror_ring + 1 >= ten) ? 0 : mirror_ring + 1;
            mirror_in_path = 1'b0;
            mirror_pos = 0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    // valid drops only when a gap is drawn, so back-to-back items keep it high
    task automatic idle_cycles();
        int n;
        n = no_idle ? 0 : $urandom_range(0, 18);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Send one vertex transaction and record what it should produce
    task automatic send_vertex(logic func, logic [VERT_W-1:0] v, logic last);
        idle_cycles();
        i_valid <= 1'b1;
        i_func <= func;
        i_vertex <= v;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        arc_results_due.push_back(predict_arc(func, v, last));
    endtask

    task automatic send_path(logic func, int len, bit pinned = 0, logic [VERT_W-1:0] v0 = 0);
        for (int i = 0; i < len; i++)
            send_vertex(func ^ (i != 0 && $urandom_range(0, 1)),
                        pinned ? v0 + VERT_W'(i) : VERT_W'($urandom), i == len - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (arc_results_due.size() != 0) @(posedge i_clk);
        // room for an update walk of a full slot after the last result
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_tenure(logic [TEN_W-1:0] t);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_tenure = t;
    endtask

    // Directed: extremes, fill and update, single-vertex paths, repeats
    task automatic test_directed();
        send_vertex(1'b0, 4'd0, 1'b0);
        send_vertex(1'b1, 4'd15, 1'b0);
        send_vertex(1'b0, 4'd0, 1'b1);
        send_vertex(1'b1, 4'd15, 1'b1);       // single-vertex path
        send_vertex(1'b1, 4'd0, 1'b0);
        send_vertex(1'b1, 4'd15, 1'b0);       // same arc again: already tabu
        send_vertex(1'b1, 4'd0, 1'b1);
        send_path(1'b1, 5, 1, 4'd3);
        send_path(1'b1, 5, 1, 4'd3);
    endtask

    task automatic test_overflow();
        send_path(1'b1, 36);
        send_path(1'b0, 34);
    endtask

    task automatic test_ring_tenure();
        logic [TEN_W-1:0] settings [6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        foreach (settings[i]) begin
            write_tenure(settings[i]);
            // repeated paths so that tabu arcs recur and slots are freed
            for (int p = 0; p < 12; p++) send_path(1'b1, $urandom_range(2, 6), 1, VERT_W'(p % 3));
        end
    endtask

    task automatic test_pause_until_empty();
        send_path(1'b1, 8);
        drain();
        no_idle = 1'b1;
        send_path(1'b1, 10);
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 650) begin
            if (sent % 300 == 150) write_tenure(4'($urandom_range(0, 15)));
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
                                               : $urandom_range(1, 8);
            if ($urandom_range(0, 2) == 0)
                send_path($urandom_range(0, 9) != 0, len, 1, VERT_W'($urandom_range(0, 3)));
            else
                send_path($urandom_range(0, 9) != 0, len);
            sent += len;
            no_idle = ($urandom_range(0, 7) == 0);
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_arc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (arc_results_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = arc_results_due.pop_front();
                if (o_arc_valid !== want.arc_valid)
                    report_mismatch("arc_valid", o_arc_valid, want.arc_valid);
                if (o_arc_position !== want.arc_position)
                    report_mismatch("arc_position", o_arc_position, want.arc_position);
                if (o_was_tabu !== want.was_tabu)
                    report_mismatch("was_tabu", o_was_tabu, want.was_tabu);
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", o_overflow, want.overflow);
                if (o_arcs_recorded !== want.arcs_recorded)
                    report_mismatch("arcs_recorded", o_arcs_recorded, want.arcs_recorded);
                if (o_path_done !== want.path_done)
                    report_mismatch("path_done", o_path_done, want.path_done);
            end
        end
    end

    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) continue;
            if (o_valid && i_ready) begin
                stall = no_idle ? 0 : $urandom_range(0, 18);
                if (stall != 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        mirror_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_ring_tenure();
        test_pause_until_empty();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
